// ===== rtl/uce_pkg.sv =====
// Shared codes, types and descriptor sizes for the USB control endpoint.
`timescale 1ns / 1ps

package uce_pkg;

  // Item modes on the request channel.
  localparam logic [1:0] MODE_BUS_RESET = 2'd0;
  localparam logic [1:0] MODE_SETUP     = 2'd1;
  localparam logic [1:0] MODE_DATA      = 2'd2;

  // Planned answer for the next data stage.
  localparam logic [1:0] PLAN_NAK   = 2'd0;
  localparam logic [1:0] PLAN_SEND  = 2'd1;
  localparam logic [1:0] PLAN_STALL = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_STALL  = 3'd1;
  localparam logic [2:0] KIND_ZLP    = 3'd2;
  localparam logic [2:0] KIND_HEADER = 3'd3;
  localparam logic [2:0] KIND_WORD   = 3'd4;

  // Standard request fields.
  localparam logic [7:0] RTYPE_DEV_IN        = 8'h80;
  localparam logic [7:0] RTYPE_DEV_OUT       = 8'h00;
  localparam logic [7:0] CODE_SET_ADDRESS    = 8'd5;
  localparam logic [7:0] CODE_GET_DESCRIPTOR = 8'd6;
  localparam logic [7:0] CODE_SET_CONFIG     = 8'd9;
  localparam logic [7:0] DTYPE_DEVICE        = 8'd1;
  localparam logic [7:0] DTYPE_CONFIG        = 8'd2;
  localparam logic [7:0] DTYPE_STRING        = 8'd3;
  localparam logic [7:0] STR_COUNT           = 8'd3;

  // Descriptor sources in the ROM.
  localparam logic [2:0] SRC_DEV  = 3'd0;
  localparam logic [2:0] SRC_CFG  = 3'd1;
  localparam logic [2:0] SRC_STR0 = 3'd2;
  localparam logic [2:0] SRC_STR1 = 3'd3;
  localparam logic [2:0] SRC_STR2 = 3'd4;

  // Address of one 32-bit word in the descriptor ROM.
  typedef struct packed {
    logic [2:0] src;
    logic [4:0] word;
  } rom_addr_t;

  // Full length in bytes of each descriptor.
  function automatic logic [7:0] desc_length(input logic [2:0] src);
    logic [7:0] n;
    case (src)
      SRC_DEV:  n = 8'd18;
      SRC_CFG:  n = 8'd32;
      SRC_STR0: n = 8'd4;
      SRC_STR1: n = 8'd18;
      SRC_STR2: n = 8'd66;
      default:  n = 8'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/uce_desc_rom.sv =====
// Descriptor ROM with one registered read port, little-endian 32-bit words.
`timescale 1ns / 1ps

module uce_desc_rom (
  input  logic              clk,
  input  uce_pkg::rom_addr_t addr,
  output logic [31:0]       q
);

  // Word contents; bytes past the end of a descriptor read as zero.
  function automatic logic [31:0] desc_word(input logic [2:0] src, input logic [4:0] w);
    logic [31:0] d;
    d = 32'h0;
    case (src)
      uce_pkg::SRC_DEV: begin
        case (w)
          5'd0:    d = 32'h02000112;
          5'd1:    d = 32'h40000000;
          5'd3:    d = 32'h02010000;
          5'd4:    d = 32'h00000100;
          default: d = 32'h0;
        endcase
      end
      uce_pkg::SRC_CFG: begin
        case (w)
          5'd0:    d = 32'h00200209;
          5'd1:    d = 32'hc0000101;
          5'd2:    d = 32'h00040900;
          5'd3:    d = 32'h00000200;
          5'd4:    d = 32'h05070000;
          5'd5:    d = 32'h00400201;
          5'd6:    d = 32'h8205070a;
          5'd7:    d = 32'h0a004002;
          default: d = 32'h0;
        endcase
      end
      uce_pkg::SRC_STR0: begin
        case (w)
          5'd0:    d = 32'h00000304;
          default: d = 32'h0;
        endcase
      end
      uce_pkg::SRC_STR1: begin
        case (w)
          5'd0:    d = 32'h004b0312;
          5'd1:    d = 32'h006d0075;
          5'd2:    d = 32'h0054006f;
          5'd3:    d = 32'h00630065;
          5'd4:    d = 32'h00000068;
          default: d = 32'h0;
        endcase
      end
      uce_pkg::SRC_STR2: begin
        case (w)
          5'd0:    d = 32'h00530342;
          5'd1:    d = 32'h004d0054;
          5'd2:    d = 32'h00320033;
          5'd3:    d = 32'h00340046;
          5'd4:    d = 32'h00690064;
          5'd5:    d = 32'h00630073;
          5'd6:    d = 32'h0076006f;
          5'd7:    d = 32'h00720065;
          5'd8:    d = 32'h00200079;
          5'd9:    d = 32'h00530055;
          5'd10:   d = 32'h00540042;
          5'd11:   d = 32'h00730065;
          5'd12:   d = 32'h00200074;
          5'd13:   d = 32'h00720050;
          5'd14:   d = 32'h006a006f;
          5'd15:   d = 32'h00630065;
          5'd16:   d = 32'h00000074;
          default: d = 32'h0;
        endcase
      end
      default: d = 32'h0;
    endcase
    return d;
  endfunction

  // Registered read.
  always_ff @(posedge clk) begin
    q <= desc_word(addr.src, addr.word);
  end

endmodule

// ===== rtl/usb_control_endpoint_requests.sv =====
// Top level of the USB control endpoint: setup decode, data stage sequencer, output beat.
//
//  channel   direction  handshake           payload
//  request   in         in_valid/in_stall   mode, request_*, tx_free_words
//  result    out        out_valid/out_stall kind ... last
//
// Bus reset, setup and plain data stage items take one beat. A data stage that sends
// takes 1 + ceil(length/4) beats, at most 18, one per cycle while the result channel
// does not stall, paced by the single read port of the descriptor ROM.
// Reset clears the plan, source, length and address; no clearing pass.
// A stalled result beat holds; the next request is taken once the sequencer
// is done and the result register is free or being emptied.
`timescale 1ns / 1ps

module usb_control_endpoint_requests #(
  parameter int MAX_PACKET = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  request_type,
  input  logic [7:0]  request_code,
  input  logic [15:0] request_value,
  input  logic [15:0] request_index,
  input  logic [15:0] request_length,
  input  logic [15:0] tx_free_words,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  transfer_length,
  output logic [1:0]  packet_count,
  output logic [31:0] data_word,
  output logic        flush_tx,
  output logic [6:0]  device_address,
  output logic        last
);

  localparam logic [8:0] PKT_ONE = 9'(MAX_PACKET);
  localparam logic [8:0] PKT_TWO = 9'(2 * MAX_PACKET);

  // Endpoint state.
  logic [1:0] plan;
  logic [2:0] src;
  logic [7:0] len;
  logic [6:0] addr;
  logic       busy;
  logic [4:0] word_idx;

  logic out_load;
  logic accept;

  assign out_load = ~out_valid | ~out_stall;
  assign in_stall = busy | ~out_load;
  assign accept   = in_valid & ~in_stall;

  // Setup packet decode.
  logic [1:0] plan_next;
  logic [2:0] src_next;
  logic [7:0] len_next;
  logic [6:0] addr_next;
  logic [7:0] dtype;
  logic [7:0] didx;
  logic [7:0] full_len;

  always_comb begin
    dtype     = request_value[15:8];
    didx      = request_value[7:0];
    plan_next = plan;
    src_next  = src;
    len_next  = len;
    addr_next = addr;
    full_len  = 8'd0;
    if (request_type == uce_pkg::RTYPE_DEV_IN &&
        request_code == uce_pkg::CODE_GET_DESCRIPTOR && request_index == 16'd0) begin
      plan_next = uce_pkg::PLAN_SEND;
      if (dtype == uce_pkg::DTYPE_DEVICE && didx == 8'd0) begin
        src_next = uce_pkg::SRC_DEV;
      end else if (dtype == uce_pkg::DTYPE_CONFIG && didx == 8'd0) begin
        src_next = uce_pkg::SRC_CFG;
      end else if (dtype == uce_pkg::DTYPE_STRING && didx < uce_pkg::STR_COUNT) begin
        src_next = uce_pkg::SRC_STR0 + didx[2:0];
      end else begin
        plan_next = uce_pkg::PLAN_STALL;
      end
      if (plan_next != uce_pkg::PLAN_STALL) begin
        full_len = uce_pkg::desc_length(src_next);
        len_next = ({8'd0, full_len} > request_length) ? request_length[7:0] : full_len;
      end
    end else if (request_type == uce_pkg::RTYPE_DEV_OUT &&
                 request_code == uce_pkg::CODE_SET_ADDRESS && request_index == 16'd0 &&
                 request_length == 16'd0 && request_value[15:7] == 9'd0) begin
      addr_next = request_value[6:0];
      plan_next = uce_pkg::PLAN_SEND;
      len_next  = 8'd0;
    end else if (request_type == uce_pkg::RTYPE_DEV_OUT &&
                 request_code == uce_pkg::CODE_SET_CONFIG && request_value == 16'd1 &&
                 request_index == 16'd0 && request_length == 16'd0) begin
      plan_next = uce_pkg::PLAN_SEND;
      len_next  = 8'd0;
    end else begin
      plan_next = uce_pkg::PLAN_STALL;
    end
  end

  // Data stage decision from the stored plan.
  logic       no_space;
  logic       data_send;
  logic [1:0] pkt_cnt;

  assign no_space  = (len != 8'd0) && (tx_free_words < {10'd0, len[7:2]});
  assign data_send = (plan == uce_pkg::PLAN_SEND) && !no_space && (len != 8'd0);

  always_comb begin
    if ({1'b0, len} < PKT_ONE) begin
      pkt_cnt = 2'd1;
    end else if ({1'b0, len} < PKT_TWO) begin
      pkt_cnt = 2'd2;
    end else begin
      pkt_cnt = 2'd3;
    end
  end

  // Descriptor ROM, read one word ahead of the output beat.
  uce_pkg::rom_addr_t rd_addr;
  logic [31:0]        rom_q;

  always_comb begin
    rd_addr.src  = src;
    rd_addr.word = busy ? (out_load ? word_idx + 5'd1 : word_idx) : 5'd0;
  end

  uce_desc_rom u_rom (
    .clk  (clk),
    .addr (rd_addr),
    .q    (rom_q)
  );

  // Byte mask for a word cut short by the transfer length.
  logic [31:0] word_masked;
  logic        word_last;
  logic [8:0]  word_end;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      word_masked[8*j +: 8] = ({2'b00, word_idx, 2'(j)} < {1'b0, len}) ?
                              rom_q[8*j +: 8] : 8'd0;
    end
    word_end  = {2'b00, word_idx, 2'b00} + 9'd4;
    word_last = word_end >= {1'b0, len};
  end

  // Contents of the next result beat.
  logic [2:0]  beat_kind;
  logic [7:0]  beat_len;
  logic [1:0]  beat_cnt;
  logic [31:0] beat_word;
  logic        beat_flush;
  logic [6:0]  beat_addr;
  logic        beat_last;

  always_comb begin
    beat_kind  = uce_pkg::KIND_NONE;
    beat_len   = 8'd0;
    beat_cnt   = 2'd0;
    beat_word  = 32'd0;
    beat_flush = 1'b0;
    beat_addr  = addr;
    beat_last  = 1'b1;
    if (busy) begin
      beat_kind = uce_pkg::KIND_WORD;
      beat_word = word_masked;
      beat_last = word_last;
    end else begin
      case (mode)
        uce_pkg::MODE_BUS_RESET: begin
          beat_addr  = 7'd0;
          beat_flush = 1'b1;
        end
        uce_pkg::MODE_SETUP: begin
          beat_addr = addr_next;
        end
        uce_pkg::MODE_DATA: begin
          if (plan == uce_pkg::PLAN_STALL || no_space) begin
            beat_kind  = uce_pkg::KIND_STALL;
            beat_flush = 1'b1;
          end else if (plan == uce_pkg::PLAN_SEND) begin
            beat_cnt = pkt_cnt;
            if (len == 8'd0) begin
              beat_kind = uce_pkg::KIND_ZLP;
            end else begin
              beat_kind = uce_pkg::KIND_HEADER;
              beat_len  = len;
              beat_last = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer, endpoint state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
      plan      <= uce_pkg::PLAN_NAK;
      src       <= uce_pkg::SRC_DEV;
      len       <= 8'd0;
      addr      <= 7'd0;
      word_idx  <= 5'd0;
    end else begin
      if (accept || (busy && out_load)) begin
        out_valid       <= 1'b1;
        kind            <= beat_kind;
        transfer_length <= beat_len;
        packet_count    <= beat_cnt;
        data_word       <= beat_word;
        flush_tx        <= beat_flush;
        device_address  <= beat_addr;
        last            <= beat_last;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        word_idx <= 5'd0;
        case (mode)
          uce_pkg::MODE_BUS_RESET: begin
            addr <= 7'd0;
          end
          uce_pkg::MODE_SETUP: begin
            plan <= plan_next;
            src  <= src_next;
            len  <= len_next;
            addr <= addr_next;
          end
          uce_pkg::MODE_DATA: begin
            plan <= uce_pkg::PLAN_NAK;
            busy <= data_send;
          end
          default: begin
          end
        endcase
      end else if (busy && out_load) begin
        word_idx <= word_idx + 5'd1;
        if (word_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // A beat that is not final always has more words pending in the sequencer.
  a_pending_words: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> busy)
    else $error("non-final beat without a pending word");

  // Every accepted request yields a result beat in the next cycle.
  a_accept_beat: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request gave no result beat");

  // The word counter never runs past the transfer length.
  a_word_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> ({2'b00, word_idx, 2'b00} < {1'b0, len}))
    else $error("word index past transfer length");

endmodule
